>>> rtl/core/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select package
// Widths, constants and the queue entry type shared by the selection block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_CHILDREN = 512;
    localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W        = 9;

    localparam int PV_W   = 20;
    localparam int SUM_W  = 37;
    localparam int PR_W   = 16;
    localparam int ACT_W  = 16;
    localparam int RND_W  = 16;
    localparam int CP_W   = 16;
    localparam int SC_W   = 48;
    localparam int TIE_W  = 10;
    localparam int ROOT_W = 32;
    localparam int MEAN_W = 32;

    localparam logic [CP_W-1:0]  CPUCT_RESET = 16'd5120;
    localparam logic [TIE_W-1:0] TIE_MAX     = 10'd1023;
    localparam int               EPS_Q16     = 66;

    // Shared divider: 64-bit dividend, 21-bit divisor, one quotient bit per cycle.
    localparam int DIV_N = 64;
    localparam int DIV_D = PV_W + 1;

    // Square root of (visits << 32): two radicand bits per step.
    localparam int SQ_RAD_W = PV_W + 32;
    localparam int SQ_STEPS = SQ_RAD_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [PV_W-1:0]  parent_visits;
        logic [SUM_W-1:0] parent_value_sum;
        logic [PR_W-1:0]  prior;
        logic [PV_W-1:0]  child_visits;
        logic [SUM_W-1:0] child_value_sum;
        logic [ACT_W-1:0] action_id;
        logic [RND_W-1:0] rand_word;
        logic             last_child;
        logic             first;   // first child of a node: latch parent terms
        logic             scored;  // position below MAX_CHILDREN
        logic [IDX_W-1:0] idx;
    } t_item;

endpackage
`default_nettype wire

>>> rtl/core/pcs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select front end
// Accepts children, tracks the position within the node and tags each item.
// ----------------------------------------------------------------------------
module pcs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pcs_pkg::PV_W-1:0]      i_parent_visits,
    input  wire logic [pcs_pkg::SUM_W-1:0]     i_parent_value_sum,
    input  wire logic [pcs_pkg::PR_W-1:0]      i_prior,
    input  wire logic [pcs_pkg::PV_W-1:0]      i_child_visits,
    input  wire logic [pcs_pkg::SUM_W-1:0]     i_child_value_sum,
    input  wire logic [pcs_pkg::ACT_W-1:0]     i_action_id,
    input  wire logic [pcs_pkg::RND_W-1:0]     i_rand_word,
    input  wire logic                          i_last_child,
    input  wire logic                          i_full,
    output logic                               o_push,
    output pcs_pkg::t_item                     o_item
);
    import pcs_pkg::*;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W+IDX_W-1:0] pos_ext;
    logic                   accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign pos_ext = {{IDX_W{1'b0}}, r_count};

    always_comb begin
        o_item.parent_visits    = i_parent_visits;
        o_item.parent_value_sum = i_parent_value_sum;
        o_item.prior            = i_prior;
        o_item.child_visits     = i_child_visits;
        o_item.child_value_sum  = i_child_value_sum;
        o_item.action_id        = i_action_id;
        o_item.rand_word        = i_rand_word;
        o_item.last_child       = i_last_child;
        o_item.first            = (r_count == '0);
        o_item.scored           = (r_count < CNT_W'(MAX_CHILDREN));
        o_item.idx              = pos_ext[IDX_W-1:0];
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_last_child) begin
                n_count = '0;
            end else if (r_count < CNT_W'(MAX_CHILDREN)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select queue
// Short first-in first-out queue between the front end and the scorer.
// ----------------------------------------------------------------------------
module pcs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcs_pkg::t_item i_item,
    input  wire logic           i_pop,
    output pcs_pkg::t_item      o_item,
    output logic                o_empty,
    output logic                o_full
);
    import pcs_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CQ_W  = $clog2(QDEPTH + 1);

    t_item            r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CQ_W-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CQ_W'(QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CQ_W'(QDEPTH))
        else $error("queue fill count above depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

endmodule
`default_nettype wire

>>> rtl/core/pcs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcs_pkg::DIV_N-1:0]   i_dividend,
    input  wire logic [pcs_pkg::DIV_D-1:0]   i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [pcs_pkg::DIV_N-1:0]        o_quot,
    output logic [pcs_pkg::DIV_D-1:0]        o_rem
);
    import pcs_pkg::*;

    localparam int STEP_W = $clog2(DIV_N);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_N-1:0]  r_num;
    logic [DIV_D-1:0]  r_den;
    logic [DIV_D-1:0]  r_rem;
    logic [DIV_D:0]    rem_sh;
    logic              ge;
    logic [DIV_D:0]    rem_sub;

    assign rem_sh  = {r_rem, r_num[DIV_N-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pcs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select back end
// Scores one queued child at a time and keeps the best child of the node.
// ----------------------------------------------------------------------------
module pcs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pcs_pkg::CP_W-1:0]    i_cfg_data,
    input  wire logic                        i_empty,
    input  wire pcs_pkg::t_item              i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [pcs_pkg::ACT_W-1:0]        o_chosen_action,
    output logic [pcs_pkg::IDX_W-1:0]        o_chosen_index
);
    import pcs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_DMEAN = 4'd2;
    localparam logic [3:0] S_Q     = 4'd3;
    localparam logic [3:0] S_QW    = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_UDIV  = 4'd7;
    localparam logic [3:0] S_UW    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_TW    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);
    localparam logic signed [SC_W-1:0] SCORE_MIN = {1'b1, {(SC_W-1){1'b0}}};

    logic [3:0]                r_state;
    t_item                     r_item;
    logic [CP_W-1:0]           r_cpuct;
    logic [ROOT_W-1:0]         r_root;
    logic signed [MEAN_W-1:0]  r_dmean;
    logic signed [SC_W-1:0]    r_q;
    logic [2*PR_W-1:0]         r_prod1;
    logic [DIV_N-1:0]          r_prod;
    logic signed [SC_W-1:0]    r_score;
    logic signed [SC_W-1:0]    r_best;
    logic [TIE_W-1:0]          r_tie;
    logic [ACT_W-1:0]          r_bact;
    logic [IDX_W-1:0]          r_bidx;
    logic [SQ_RAD_W-1:0]       r_rad;
    logic [SQ_REM_W-1:0]       r_srem;
    logic [SQ_ROOT_W-1:0]      r_sroot;
    logic [SQ_CNT_W-1:0]       r_scnt;
    logic                      r_ovalid;
    logic [ACT_W-1:0]          r_oact;
    logic [IDX_W-1:0]          r_oidx;

    // Divider hookup.
    logic                      div_start;
    logic [DIV_N-1:0]          div_num;
    logic [DIV_D-1:0]          div_den;
    logic                      div_busy;
    logic                      div_done;
    logic [DIV_N-1:0]          div_quot;
    logic [DIV_D-1:0]          div_rem;

    // Square-root step.
    logic [SQ_REM_W+1:0]       sq_sh;
    logic [SQ_REM_W+1:0]       sq_trial;
    logic                      sq_ge;
    logic [SQ_REM_W+1:0]       sq_sub;

    // Signed helpers.
    logic [SUM_W-1:0]          psum_mag;
    logic [SUM_W-1:0]          csum_mag;
    logic [DIV_N-1:0]          sq_neg;
    logic signed [DIV_N-1:0]   quot_signed;
    logic signed [DIV_N-1:0]   u_full;
    logic signed [SC_W+1:0]    sc_ext;
    logic signed [SC_W+1:0]    best_ext;
    logic                      better;
    logic                      tied;
    logic [TIE_W-1:0]          tie_next;
    logic                      out_take;
    logic                      out_free;

    pcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign sq_sh    = {r_srem, r_rad[SQ_RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_sroot, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_sub   = sq_sh - sq_trial;

    assign psum_mag = r_item.parent_value_sum[SUM_W-1] ?
                      (~r_item.parent_value_sum + 1'b1) : r_item.parent_value_sum;
    assign csum_mag = r_item.child_value_sum[SUM_W-1] ?
                      (~r_item.child_value_sum + 1'b1) : r_item.child_value_sum;

    // Applies the dividend sign to the quotient; which sign depends on the state.
    assign sq_neg      = ~div_quot + 1'b1;
    assign quot_signed = (r_state == S_DMEAN) ?
                         (r_item.parent_value_sum[SUM_W-1] ? sq_neg : div_quot) :
                         (r_item.child_value_sum[SUM_W-1] ? sq_neg : div_quot);
    assign u_full      = div_quot >> 28;

    assign sc_ext   = {{2{r_score[SC_W-1]}}, r_score};
    assign best_ext = {{2{r_best[SC_W-1]}}, r_best};
    assign better   = (sc_ext >= best_ext + (SC_W+2)'(EPS_Q16));
    assign tied     = (sc_ext > best_ext - (SC_W+2)'(EPS_Q16));
    assign tie_next = (r_tie < TIE_MAX) ? r_tie + 1'b1 : r_tie;

    assign out_take = r_ovalid && !i_stall;
    assign out_free = !r_ovalid || out_take;

    assign o_pop           = (r_state == S_IDLE) && !i_empty;
    assign o_valid         = r_ovalid;
    assign o_chosen_action = r_oact;
    assign o_chosen_index  = r_oidx;

    always_comb begin
        div_start = 1'b0;
        div_num   = r_prod;
        div_den   = DIV_D'(r_item.child_visits) + 1'b1;
        case (r_state)
            S_SQRT: begin
                div_num   = DIV_N'(psum_mag);
                div_den   = DIV_D'(r_item.parent_visits);
                div_start = (r_scnt == SQ_CNT_W'(SQ_STEPS)) &&
                            (r_item.parent_visits != '0);
            end
            S_Q: begin
                div_num   = DIV_N'(csum_mag);
                div_den   = DIV_D'(r_item.child_visits);
                div_start = r_item.scored && (r_item.child_visits != '0);
            end
            S_UDIV: begin
                div_start = 1'b1;
            end
            S_CMP: begin
                div_num   = DIV_N'(r_item.rand_word);
                div_den   = DIV_D'(tie_next);
                div_start = !better && tied;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        case (r_state)
            S_IDLE: begin
                r_rad   <= {i_item.parent_visits, 32'd0};
                r_srem  <= '0;
                r_sroot <= '0;
            end
            S_SQRT: begin
                if (r_scnt != SQ_CNT_W'(SQ_STEPS)) begin
                    r_rad   <= {r_rad[SQ_RAD_W-3:0], 2'b00};
                    r_srem  <= sq_ge ? sq_sub[SQ_REM_W-1:0] : sq_sh[SQ_REM_W-1:0];
                    r_sroot <= {r_sroot[SQ_ROOT_W-2:0], sq_ge};
                end
            end
            S_QW: begin
                if (div_done) begin
                    r_q <= quot_signed[SC_W-1:0];
                end
            end
            S_Q: begin
                r_q <= SC_W'(r_dmean);
            end
            S_MUL1: begin
                r_prod1 <= r_cpuct * r_item.prior;
            end
            S_MUL2: begin
                r_prod <= r_prod1 * r_root;
            end
            S_UW: begin
                if (div_done) begin
                    r_score <= r_q + u_full[SC_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cpuct  <= CPUCT_RESET;
            r_root   <= '0;
            r_dmean  <= '0;
            r_best   <= SCORE_MIN;
            r_tie    <= '0;
            r_bact   <= '0;
            r_bidx   <= '0;
            r_scnt   <= '0;
            r_ovalid <= 1'b0;
            r_oact   <= '0;
            r_oidx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cpuct <= i_cfg_data;
            end
            // A finished node loads the output register; otherwise a transfer
            // empties it.
            if ((r_state == S_FIN) && r_item.last_child && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_scnt <= '0;
                    if (!i_empty) begin
                        r_state <= i_item.first ? S_SQRT : S_Q;
                    end
                end
                S_SQRT: begin
                    if (r_scnt != SQ_CNT_W'(SQ_STEPS)) begin
                        r_scnt <= r_scnt + 1'b1;
                    end else begin
                        r_root <= ROOT_W'(r_sroot);
                        if (r_item.parent_visits == '0) begin
                            r_dmean <= '0;
                            r_state <= S_Q;
                        end else begin
                            r_state <= S_DMEAN;
                        end
                    end
                end
                S_DMEAN: begin
                    if (div_done) begin
                        if (quot_signed > DIV_N'(64'sh7FFF_FFFF)) begin
                            r_dmean <= 32'sh7FFF_FFFF;
                        end else if (quot_signed < -DIV_N'(64'sh8000_0000)) begin
                            r_dmean <= 32'sh8000_0000;
                        end else begin
                            r_dmean <= quot_signed[MEAN_W-1:0];
                        end
                        r_state <= S_Q;
                    end
                end
                S_Q: begin
                    if (!r_item.scored) begin
                        r_state <= S_FIN;
                    end else if (r_item.child_visits != '0) begin
                        r_state <= S_QW;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_QW: begin
                    if (div_done) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_UDIV;
                end
                S_UDIV: begin
                    r_state <= S_UW;
                end
                S_UW: begin
                    if (div_done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (better) begin
                        r_tie   <= TIE_W'(1);
                        r_best  <= r_score;
                        r_bact  <= r_item.action_id;
                        r_bidx  <= r_item.idx;
                        r_state <= S_FIN;
                    end else if (tied) begin
                        r_tie   <= tie_next;
                        r_state <= S_TW;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_TW: begin
                    if (div_done) begin
                        if (div_rem == '0) begin
                            r_bact <= r_item.action_id;
                            r_bidx <= r_item.idx;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_item.last_child) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_oact   <= r_bact;
                        r_oidx   <= r_bidx;
                        r_best   <= SCORE_MIN;
                        r_tie    <= '0;
                        r_bact   <= '0;
                        r_bidx   <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_new_best_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && better |=> (r_tie == TIE_W'(1)))
        else $error("new best score did not restart the tie count");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while no child is in work");
    a_tie_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TW) |-> (r_tie != '0))
        else $error("tie draw with an empty tie count");

endmodule
`default_nettype wire

>>> rtl/core/puct_child_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT child select
// Streams the children of one tree node and returns the child with the
// highest PUCT score, breaking near-ties by reservoir sampling.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  child     in         i_valid / o_stall      parent and child fields, last flag
//  choice    out        o_valid / i_stall      chosen action and index
//  config    in         i_cfg_valid / o_cfg_ready  c_puct (Q4.12)
//
// A child with visits takes longer to score than one without, since its mean
// takes a 64-step division. The first child of a node adds a 26-step square
// root and, when the parent has visits, a 64-step mean division. A score that
// ties the best adds a division for the tie draw. The shared divider gives one
// quotient bit per cycle. Reset is synchronous and active low; it restores
// c_puct to 1.25 and clears all node state. A two-entry queue lets new
// children transfer in while the scorer works; a held choice stalls the
// scorer, and the child input as well once the queue is full.
// ----------------------------------------------------------------------------
module puct_child_select (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pcs_pkg::PV_W-1:0]      i_parent_visits,
    input  wire logic [pcs_pkg::SUM_W-1:0]     i_parent_value_sum,
    input  wire logic [pcs_pkg::PR_W-1:0]      i_prior,
    input  wire logic [pcs_pkg::PV_W-1:0]      i_child_visits,
    input  wire logic [pcs_pkg::SUM_W-1:0]     i_child_value_sum,
    input  wire logic [pcs_pkg::ACT_W-1:0]     i_action_id,
    input  wire logic [pcs_pkg::RND_W-1:0]     i_rand_word,
    input  wire logic                          i_last_child,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pcs_pkg::ACT_W-1:0]          o_chosen_action,
    output logic [pcs_pkg::IDX_W-1:0]          o_chosen_index,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pcs_pkg::CP_W-1:0]      i_cfg_data
);
    import pcs_pkg::*;

    t_item q_in;
    t_item q_out;
    logic  q_push;
    logic  q_pop;
    logic  q_empty;
    logic  q_full;

    // The register accepts a write on every cycle.
    assign o_cfg_ready = 1'b1;

    // The front end tags each child with its position and first/scored flags.
    pcs_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_parent_visits    (i_parent_visits),
        .i_parent_value_sum (i_parent_value_sum),
        .i_prior            (i_prior),
        .i_child_visits     (i_child_visits),
        .i_child_value_sum  (i_child_value_sum),
        .i_action_id        (i_action_id),
        .i_rand_word        (i_rand_word),
        .i_last_child       (i_last_child),
        .i_full             (q_full),
        .o_push             (q_push),
        .o_item             (q_in)
    );

    pcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end scores one child at a time and holds the node's best child.
    pcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_empty         (q_empty),
        .i_item          (q_out),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chosen_action (o_chosen_action),
        .o_chosen_index  (o_chosen_index)
    );

endmodule
`default_nettype wire
